FILE: hw/rtl/bounded_undo_redo_history_assert.svh
// assertion macros used by the history port checker
`ifndef BOUNDED_UNDO_REDO_HISTORY_ASSERT_SVH
`define BOUNDED_UNDO_REDO_HISTORY_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BURH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("history check failed");

// next-cycle implication, sampled on clk, off while in reset
`define BURH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("history check failed");

`endif

FILE: hw/rtl/burh_pkg.sv
// package for the bounded undo/redo history: sizes, types and operation codes
package burh_pkg;

	localparam int MAX_ENTRIES = 40;
	localparam int ENTRY_WIDTH = 64;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int SUM_W       = CNT_W + 1;

	typedef logic [ENTRY_WIDTH-1:0] entry_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [SUM_W-1:0]       sum_t;

	typedef enum logic [1:0] {
		KIND_PUSH    = 2'd0,
		KIND_BACK    = 2'd1,
		KIND_FORWARD = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

endpackage

FILE: hw/rtl/bounded_undo_redo_history.sv
// Bounded undo/redo history: an accepted word passes stage one, then the result register.
// Throughput is one word per cycle while no result stalls: the counters update in one pass
// and the ring store has one port, used for the push write or the step read of that word.
// A result register plus a stage-one buffer let input words be taken while a result waits.
// Reset (arst_n low) clears count, position, oldest slot and the valid flags at once;
// the ring store is not cleared and is never read before it is written.
module bounded_undo_redo_history (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [1:0]                      kind,
	input  logic [burh_pkg::ENTRY_WIDTH-1:0] entry_in,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic                            moved,
	output logic [burh_pkg::ENTRY_WIDTH-1:0] entry_out,
	output logic                            can_go_back,
	output logic                            can_go_forward
);

	// ring slot of logical entry idx, counted from the oldest
	function automatic burh_pkg::slot_t slot_of(burh_pkg::slot_t oldest, burh_pkg::cnt_t idx);
		burh_pkg::sum_t sum;
		sum = burh_pkg::sum_t'(oldest) + burh_pkg::sum_t'(idx);
		if (sum >= burh_pkg::sum_t'(burh_pkg::MAX_ENTRIES))
			sum = sum - burh_pkg::sum_t'(burh_pkg::MAX_ENTRIES);
		return sum[burh_pkg::SLOT_W-1:0];
	endfunction

	localparam burh_pkg::cnt_t CNT_MAX  = burh_pkg::cnt_t'(burh_pkg::MAX_ENTRIES);
	localparam burh_pkg::cnt_t CNT_ONE  = burh_pkg::cnt_t'(1);
	localparam burh_pkg::slot_t SLOT_LAST = burh_pkg::slot_t'(burh_pkg::MAX_ENTRIES - 1);

	// history state
	burh_pkg::slot_t oldest_q;
	burh_pkg::cnt_t  count_q;
	burh_pkg::cnt_t  pos_q;

	// ring store
	burh_pkg::entry_t store_mem [burh_pkg::MAX_ENTRIES];

	// stage one: flags and store read data
	logic             valid_s1;
	logic             moved_s1;
	logic             back_s1;
	logic             fwd_s1;
	burh_pkg::entry_t rdata_s1;

	// result register
	logic             out_valid_q;
	logic             moved_q;
	logic             back_q;
	logic             fwd_q;
	burh_pkg::entry_t entry_q;

	logic             accept;
	logic             s1_move;
	burh_pkg::kind_t  op;
	burh_pkg::cnt_t   base_cnt;
	burh_pkg::cnt_t   pos_lim;
	burh_pkg::cnt_t   idx;
	burh_pkg::slot_t  addr;
	burh_pkg::slot_t  next_oldest;
	burh_pkg::cnt_t   next_count;
	burh_pkg::cnt_t   next_pos;
	logic             do_write;
	logic             do_move;

	// handshake between the stages
	assign s1_move    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_move;
	assign accept     = item_valid && item_ready;
	assign op         = burh_pkg::kind_t'(kind);

	// truncate to the position, and the position limited to 1..count (0 when empty)
	always_comb begin
		base_cnt = (count_q > pos_q) ? pos_q : count_q;
		pos_lim  = (pos_q < CNT_ONE) ? CNT_ONE : pos_q;
		if (pos_lim > count_q)
			pos_lim = count_q;
	end

	// next state, store access and move flag
	always_comb begin
		next_oldest = oldest_q;
		next_count  = count_q;
		next_pos    = pos_q;
		do_write    = 1'b0;
		do_move     = 1'b0;
		idx         = base_cnt;
		unique case (op)
			burh_pkg::KIND_PUSH: begin
				do_write = 1'b1;
				idx      = base_cnt;
				if (base_cnt == CNT_MAX) begin
					next_oldest = (oldest_q == SLOT_LAST) ? '0 : oldest_q + 1'b1;
					next_count  = CNT_MAX;
				end else begin
					next_count = base_cnt + 1'b1;
				end
				next_pos = (base_cnt == CNT_MAX) ? CNT_MAX : base_cnt + 1'b1;
			end
			burh_pkg::KIND_BACK: begin
				if (count_q != '0) begin
					next_pos = pos_lim;
					if (pos_lim > CNT_ONE) begin
						next_pos = pos_lim - 1'b1;
						do_move  = 1'b1;
					end
				end
				idx = next_pos - 1'b1;
			end
			burh_pkg::KIND_FORWARD: begin
				if (count_q != '0) begin
					next_pos = pos_lim;
					if (pos_lim < count_q) begin
						next_pos = pos_lim + 1'b1;
						do_move  = 1'b1;
					end
				end
				idx = next_pos - 1'b1;
			end
			burh_pkg::KIND_CLEAR: begin
				next_oldest = '0;
				next_count  = '0;
				next_pos    = '0;
			end
			default: begin
				next_oldest = oldest_q;
			end
		endcase
		addr = slot_of(oldest_q, idx);
	end

	// history state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			oldest_q <= next_oldest;
			count_q  <= next_count;
			pos_q    <= next_pos;
		end
	end

	// ring store, one port: push writes, a step reads
	always_ff @(posedge clk) begin
		if (accept && do_write)
			store_mem[addr] <= entry_in;
		if (accept && do_move)
			rdata_s1 <= store_mem[addr];
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one flags
	always_ff @(posedge clk) begin
		if (accept) begin
			moved_s1 <= do_move;
			back_s1  <= next_pos > CNT_ONE;
			fwd_s1   <= next_pos < next_count;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (s1_move) begin
			moved_q <= moved_s1;
			back_q  <= back_s1;
			fwd_q   <= fwd_s1;
			entry_q <= moved_s1 ? rdata_s1 : '0;
		end
	end

	assign result_valid   = out_valid_q;
	assign moved          = moved_q;
	assign entry_out      = entry_q;
	assign can_go_back    = back_q;
	assign can_go_forward = fwd_q;

endmodule

FILE: hw/rtl/burh_checker.sv
// port checker for the bounded undo/redo history, with its bind
`include "bounded_undo_redo_history_assert.svh"

module burh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic                            moved,
	input logic [burh_pkg::ENTRY_WIDTH-1:0] entry_out,
	input logic                            can_go_back,
	input logic                            can_go_forward
);

	// whole result word as one vector
	logic [burh_pkg::ENTRY_WIDTH+2:0] word;

	assign word = {moved, entry_out, can_go_back, can_go_forward};

	// a stalled result word holds
	`BURH_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(word))

	// no move means a zero entry word
	`BURH_ASSERT_NOW(a_entry_zero, result_valid && !moved, entry_out == '0)

	// after a move at least two entries exist, so one direction stays open
	`BURH_ASSERT_NOW(a_move_flags, result_valid && moved, can_go_back || can_go_forward)

	// input back-pressure only while a result is waiting
	`BURH_ASSERT_NOW(a_ready_low, !item_ready, result_valid && !result_ready)

endmodule

bind bounded_undo_redo_history burh_checker u_burh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.moved          (moved),
	.entry_out      (entry_out),
	.can_go_back    (can_go_back),
	.can_go_forward (can_go_forward)
);
